>>> hdl/sps_pkg.sv
// ============================================================================
// sps_pkg - shared types and constants for the seeded permutation shuffler
// Word layouts, status codes, register indexes and the xorshift32 step.
// ============================================================================
package sps_pkg;

   localparam int ENTRY_W    = 14;  // stored table entry
   localparam int POS_W      = 14;  // read position
   localparam int COUNT_W    = 15;  // count register
   localparam int SEED_W     = 32;  // generator width
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;   // two registers at byte addresses 0 and 4
   localparam int DIV_STEPS  = SEED_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;

   localparam logic [SEED_W-1:0]  SEED_RESET  = 32'd2;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 15'd9000;

   typedef enum logic {
      FUNC_SHUFFLE = 1'b0,
      FUNC_READ    = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_READ_OK  = 2'd0,
      STATUS_DONE     = 2'd1,
      STATUS_READ_ERR = 2'd2
   } status_type;

   typedef enum logic {
      CSR_SEED  = 1'b0,
      CSR_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_DRAW,
      S_DIV,
      S_RD_TOP,
      S_RD_PICK,
      S_WR_TOP,
      S_WR_PICK,
      S_DONE
   } state_type;

   typedef struct packed {
      func_type          func;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] entry_value;
      status_type         status;
   } rsp_type;

   // one xorshift32 draw
   function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] x);
      logic [SEED_W-1:0] a;
      logic [SEED_W-1:0] b;
      a = x ^ (x << SHIFT_A);
      b = a ^ (a >> SHIFT_B);
      return b ^ (b << SHIFT_C);
   endfunction

endpackage

>>> hdl/seeded_permutation_shuffler_core.sv
// ============================================================================
// seeded_permutation_shuffler_core - Fisher-Yates shuffle table, xorshift32
// Holds a permutation table in one synchronous RAM, rebuilds it on command
// and serves single-position reads.
// ============================================================================
// A read word is taken whenever busy is low and answers in the cycle after,
// so reads stream at one per cycle while busy is low. A shuffle word raises
// busy until its done word: the fill state writes the table with 0..n-1,
// then each of the n-1 swap steps makes one draw, runs the bit-serial
// remainder unit and does two reads and two writes on the table RAM, then
// the done state follows; n is the count register capped at
// MAX_RECORDS.
// The receiver cannot stall: each result word is on rsp_data for exactly the
// one cycle that rsp_valid is high. Table entries hold no reset; a read is
// refused before the first shuffle and at positions not below the current capped count.
module seeded_permutation_shuffler_core #(
   parameter int MAX_RECORDS = 16384
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 start,
   output logic                                 busy,
   input  sps_pkg::req_type                     req_data,
   // result channel
   output logic                                 rsp_valid,
   output sps_pkg::rsp_type                     rsp_data,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sps_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [sps_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [sps_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   // table address width and a count width that holds both the count
   // register and MAX_RECORDS itself
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = (AW + 1 > sps_pkg::COUNT_W) ? AW + 1 : sps_pkg::COUNT_W;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_RECORDS);

   // ---------------------------------------------------------------- state
   sps_pkg::state_type                state_ff, state_in;

   logic [sps_pkg::SEED_W-1:0]        seed_ff,  seed_in;
   logic [sps_pkg::COUNT_W-1:0]       count_ff, count_in;

   logic [sps_pkg::SEED_W-1:0]        gen_ff,   gen_in;    // generator
   logic                              valid_ff, valid_in;  // a shuffle has run
   logic                              rd_pend_ff, rd_pend_in;
   logic                              rd_ok_ff, rd_ok_in;

   logic [CW-1:0]                     idx_ff,   idx_in;    // fill counter
   logic [CW-1:0]                     cnt_ff,   cnt_in;    // count latched at start
   logic [AW-1:0]                     top_ff,   top_in;    // Fisher-Yates index i-1
   logic [sps_pkg::SEED_W-1:0]        dvd_ff,   dvd_in;    // dividend, shifted out msb first
   logic [CW-1:0]                     rem_ff,   rem_in;    // partial remainder / pick
   logic [sps_pkg::DIV_CNT_W-1:0]     step_ff,  step_in;
   logic [sps_pkg::ENTRY_W-1:0]       held_ff,  held_in;   // entry at top during swap

   // table RAM: one write, one registered read per cycle
   logic [sps_pkg::ENTRY_W-1:0]       table_mem [MAX_RECORDS];
   logic [sps_pkg::ENTRY_W-1:0]       mem_q;
   logic                              mem_we;
   logic [AW-1:0]                     mem_wa;
   logic [sps_pkg::ENTRY_W-1:0]       mem_wd;
   logic [AW-1:0]                     mem_ra;

   logic [CW-1:0]                     eff_count;
   logic [CW-1:0]                     pos_ext;
   logic [CW-1:0]                     divisor;
   logic [CW:0]                       trial;
   logic [CW:0]                       diff;
   logic [CW-1:0]                     rem_next;
   logic [sps_pkg::SEED_W-1:0]        draw;
   logic                              csr_wr;
   sps_pkg::csr_index_type            csr_idx;

   // ------------------------------------------------------------ registers
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = sps_pkg::csr_index_type'(paddr[2]);

   always_comb begin
      seed_in  = seed_ff;
      count_in = count_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            sps_pkg::CSR_SEED:  seed_in  = pwdata;
            sps_pkg::CSR_COUNT: count_in = pwdata[sps_pkg::COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         sps_pkg::CSR_SEED:  prdata = seed_ff;
         sps_pkg::CSR_COUNT: prdata = sps_pkg::CSR_DATA_W'(count_ff);
      endcase
   end

   // counts above the table depth saturate
   always_comb begin
      eff_count = (CW'(count_ff) > MAX_COUNT) ? MAX_COUNT : CW'(count_ff);
      pos_ext   = CW'(req_data.position);
   end

   // ------------------------------------------------ bit-serial remainder
   // restoring step: shift in one dividend bit, subtract i when it fits
   always_comb begin
      divisor  = CW'(top_ff) + CW'(1);
      trial    = {rem_ff, dvd_ff[sps_pkg::SEED_W-1]};
      diff     = trial - {1'b0, divisor};
      rem_next = (trial >= {1'b0, divisor}) ? diff[CW-1:0] : trial[CW-1:0];
      draw     = sps_pkg::xorshift(gen_ff);
   end

   // ----------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      gen_in     = gen_ff;
      valid_in   = valid_ff;
      rd_pend_in = 1'b0;
      rd_ok_in   = rd_ok_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      top_in     = top_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      held_in    = held_ff;
      mem_we     = 1'b0;
      mem_wa     = top_ff;
      mem_wd     = mem_q;
      mem_ra     = AW'(req_data.position);

      unique case (state_ff)
         sps_pkg::S_IDLE: begin
            if (start) begin
               if (req_data.func == sps_pkg::FUNC_SHUFFLE) begin
                  gen_in   = seed_ff;
                  idx_in   = '0;
                  cnt_in   = eff_count;
                  state_in = sps_pkg::S_FILL;
               end else begin
                  rd_pend_in = 1'b1;
                  rd_ok_in   = valid_ff && (pos_ext < eff_count);
               end
            end
         end
         sps_pkg::S_FILL: begin
            if (idx_ff == cnt_ff) begin
               top_in   = AW'(cnt_ff - CW'(1));
               state_in = (cnt_ff > CW'(1)) ? sps_pkg::S_DRAW : sps_pkg::S_DONE;
            end else begin
               mem_we = 1'b1;
               mem_wa = idx_ff[AW-1:0];
               mem_wd = idx_ff[sps_pkg::ENTRY_W-1:0];
               idx_in = idx_ff + CW'(1);
            end
         end
         sps_pkg::S_DRAW: begin
            gen_in   = draw;
            dvd_in   = draw;
            rem_in   = '0;
            step_in  = '0;
            state_in = sps_pkg::S_DIV;
         end
         sps_pkg::S_DIV: begin
            rem_in  = rem_next;
            dvd_in  = {dvd_ff[sps_pkg::SEED_W-2:0], 1'b0};
            step_in = step_ff + sps_pkg::DIV_CNT_W'(1);
            if (step_ff == sps_pkg::DIV_CNT_W'(sps_pkg::DIV_STEPS - 1)) begin
               state_in = sps_pkg::S_RD_TOP;
            end
         end
         sps_pkg::S_RD_TOP: begin
            mem_ra   = top_ff;
            state_in = sps_pkg::S_RD_PICK;
         end
         sps_pkg::S_RD_PICK: begin
            mem_ra   = rem_ff[AW-1:0];
            held_in  = mem_q;                // entry at top
            state_in = sps_pkg::S_WR_TOP;
         end
         sps_pkg::S_WR_TOP: begin
            mem_we   = 1'b1;                 // top <- entry at pick
            mem_wa   = top_ff;
            mem_wd   = mem_q;
            state_in = sps_pkg::S_WR_PICK;
         end
         sps_pkg::S_WR_PICK: begin
            mem_we = 1'b1;                   // pick <- old entry at top
            mem_wa = rem_ff[AW-1:0];
            mem_wd = held_ff;
            if (top_ff == AW'(1)) begin
               state_in = sps_pkg::S_DONE;
            end else begin
               top_in   = top_ff - AW'(1);
               state_in = sps_pkg::S_DRAW;
            end
         end
         sps_pkg::S_DONE: begin
            valid_in = 1'b1;
            state_in = sps_pkg::S_IDLE;
         end
         default: begin
            state_in = sps_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sps_pkg::S_IDLE;
         seed_ff    <= sps_pkg::SEED_RESET;
         count_ff   <= sps_pkg::COUNT_RESET;
         gen_ff     <= '0;
         valid_ff   <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         seed_ff    <= seed_in;
         count_ff   <= count_in;
         gen_ff     <= gen_in;
         valid_ff   <= valid_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      top_ff   <= top_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      held_ff  <= held_in;
   end

   // ------------------------------------------------------------ table RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      mem_q <= table_mem[mem_ra];
   end

   // -------------------------------------------------------------- outputs
   assign busy      = (state_ff != sps_pkg::S_IDLE);
   assign rsp_valid = rd_pend_ff | (state_ff == sps_pkg::S_DONE);

   always_comb begin
      rsp_data.entry_value = (rd_pend_ff && rd_ok_ff) ? mem_q : '0;
      if (state_ff == sps_pkg::S_DONE) begin
         rsp_data.status = sps_pkg::STATUS_DONE;
      end else if (rd_ok_ff) begin
         rsp_data.status = sps_pkg::STATUS_READ_OK;
      end else begin
         rsp_data.status = sps_pkg::STATUS_READ_ERR;
      end
   end

endmodule
